/* rtl/acl_pkg.sv */
// Package for the associative cache metadata controller.
// Holds sizes, operation and status codes, and the structs shared by the RTL modules.
// No dependencies.
package acl_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int TAG_W   = 64;
  localparam int STAMP_W = 32;
  localparam int SIZE_W  = 21;
  localparam int BSIZE_W = 24;
  localparam int SLOT_W  = 4;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;

  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = SIZE_W'(4096);

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [SIZE_W-1:0]  size_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP    = 2'd0,
    OP_INVAL     = 2'd1,
    OP_INVAL_ALL = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT         = 3'd0,
    ST_FILLED      = 3'd1,
    ST_NOT_CACHED  = 3'd2,
    ST_INVALIDATED = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_ALL_CLEARED = 3'd5
  } status_t;

  // One stored entry of the metadata memory.
  typedef struct packed {
    tag_t   tag;
    stamp_t stamp;
    size_t  size;
  } meta_t;

  // Outcome of a full pass over the entries.
  typedef struct packed {
    logic  hit;
    idx_t  hit_idx;
    size_t hit_size;
    logic  free;
    idx_t  free_idx;
    logic  evict;
    idx_t  evict_idx;
  } scan_res_t;

endpackage

/* rtl/acl_meta_ram.sv */
// Metadata memory: tag, access stamp and size for every entry.
// One write port, one read port, read data registered. Uses acl_pkg.
module acl_meta_ram
  import acl_pkg::*;
(
  input  logic  clk,
  input  logic  we,
  input  idx_t  waddr,
  input  meta_t wdata,
  input  logic  re,
  input  idx_t  raddr,
  output meta_t rdata
);

  meta_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/acl_scan.sv */
// Scan unit: checks one entry per cycle as it comes out of the metadata memory.
// Tracks the first tag match, the first free entry and the oldest evictable entry.
// Uses acl_pkg.
module acl_scan
  import acl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tag_t               start_tag,
  input  stamp_t             start_now,
  input  logic               issue,
  input  idx_t               issue_idx,
  input  logic [ENTRIES-1:0] entry_valid,
  input  meta_t              rd_data,
  output scan_res_t          res
);

  logic   chk_vld;
  idx_t   chk_idx;
  tag_t   req_tag;
  stamp_t oldest;
  logic   chk_v;

  // The read data of the entry issued last cycle is valid now.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else begin
      chk_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      chk_idx <= issue_idx;
    end
  end

  assign chk_v = entry_valid[chk_idx];

  always_ff @(posedge clk) begin
    if (start) begin
      req_tag   <= start_tag;
      oldest    <= start_now;
      res.hit   <= 1'b0;
      res.free  <= 1'b0;
      res.evict <= 1'b0;
    end else if (chk_vld) begin
      if (chk_v && (rd_data.tag == req_tag) && !res.hit) begin
        res.hit      <= 1'b1;
        res.hit_idx  <= chk_idx;
        res.hit_size <= rd_data.size;
      end
      if (!chk_v && !res.free) begin
        res.free     <= 1'b1;
        res.free_idx <= chk_idx;
      end
      // A later entry with an equal stamp takes over, so ties go to the last index.
      if (rd_data.stamp <= oldest) begin
        oldest        <= rd_data.stamp;
        res.evict     <= 1'b1;
        res.evict_idx <= chk_idx;
      end
    end
  end

endmodule

/* rtl/assoc_cache_lru_timestamp.sv */
// Fully associative cache metadata controller with timestamp LRU eviction.
// Cacheable lookup and tag invalidation first read every entry from the memory in SCAN,
// check the last read data in LAST, and then decide and load the result in DECIDE.
// Other requests go straight to DECIDE. One transaction at a time: in_ready returns
// the cycle after the result is loaded, and the decision waits while an older result is held.
// Synchronous active-high reset clears state, valid bits, out_valid; max_entry_size = 4096.
module assoc_cache_lru_timestamp
  import acl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration port
  input  logic                 cfg_wr_en,
  input  logic [SIZE_W-1:0]    cfg_wr_data,
  // Request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      op,
  input  logic [TAG_W-1:0]     tag,
  input  logic                 cacheable,
  input  logic [STAMP_W-1:0]   now,
  input  logic                 backing_open_ok,
  input  logic [BSIZE_W-1:0]   backing_size,
  input  logic                 backing_read_ok,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    status,
  output logic [SLOT_W-1:0]    slot,
  output logic [SIZE_W-1:0]    entry_bytes
);

  // The controller walks through these states for each transaction. IDLE waits for a
  // request, SCAN issues one memory read per entry, LAST checks the final read data,
  // and DECIDE applies the update and loads the result register. Requests that need no scan go straight to DECIDE.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_LAST   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  size_t max_entry_size;

  // Registered request.
  logic [OP_W-1:0]    req_op;
  tag_t               req_tag;
  logic               req_cacheable;
  stamp_t             req_now;
  logic               req_open_ok;
  logic [BSIZE_W-1:0] req_bsize;
  logic               req_read_ok;

  logic [ENTRIES-1:0] entry_valid;
  logic [ENTRIES-1:0] entry_valid_next;

  idx_t      rd_idx;
  logic      rd_en;
  meta_t     rd_data;
  scan_res_t scan_res;

  logic      accept;
  logic      needs_scan;
  logic      fire;

  logic      mem_we;
  idx_t      mem_waddr;
  meta_t     mem_wdata;
  status_t   res_status;
  idx_t      res_idx;
  size_t     res_bytes;
  idx_t      claim_idx;
  logic      claim_any;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Only a cacheable lookup or tag invalidation needs to look at the stored entries.
  assign needs_scan = cacheable && ((op == OP_LOOKUP) || (op == OP_INVAL));

  // The result register must be free before a decision is committed.
  assign fire = (state == S_DECIDE) && (!out_valid || out_ready);

  assign rd_en = (state == S_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entry_size <= MAX_SIZE_RST;
    end else if (cfg_wr_en) begin
      max_entry_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op        <= op;
      req_tag       <= tag;
      req_cacheable <= cacheable;
      req_now       <= now;
      req_open_ok   <= backing_open_ok;
      req_bsize     <= backing_size;
      req_read_ok   <= backing_read_ok;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = needs_scan ? S_SCAN : S_DECIDE;
        end
      end
      S_SCAN: begin
        if (rd_idx == idx_t'(ENTRIES - 1)) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_idx <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        rd_idx <= '0;
      end else if (rd_en) begin
        rd_idx <= rd_idx + idx_t'(1);
      end
    end
  end

  // The metadata memory is only written when the decision is committed, so the scan of a
  // transaction never sees a partial update from its own intermediate results.
  acl_meta_ram u_meta_ram (
    .clk   (clk),
    .we    (mem_we && fire),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  acl_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .start_tag   (tag),
    .start_now   (now),
    .issue       (rd_en),
    .issue_idx   (rd_idx),
    .entry_valid (entry_valid),
    .rd_data     (rd_data),
    .res         (scan_res)
  );

  // A miss prefers the lowest free entry; only when every entry is in use does it
  // fall back to the oldest stamp that is not later than the request time.
  assign claim_any = scan_res.free || scan_res.evict;
  assign claim_idx = scan_res.free ? scan_res.free_idx : scan_res.evict_idx;

  always_comb begin
    entry_valid_next = entry_valid;
    mem_we           = 1'b0;
    mem_waddr        = claim_idx;
    mem_wdata.tag    = req_tag;
    mem_wdata.stamp  = req_now;
    mem_wdata.size   = req_bsize[SIZE_W-1:0];
    res_status       = ST_NOT_FOUND;
    res_idx          = '0;
    res_bytes        = '0;
    unique case (req_op)
      OP_LOOKUP: begin
        res_status = ST_NOT_CACHED;
        if (req_cacheable) begin
          if (scan_res.hit) begin
            // A hit only refreshes the stamp; tag and size are written back unchanged.
            mem_we         = 1'b1;
            mem_waddr      = scan_res.hit_idx;
            mem_wdata.size = scan_res.hit_size;
            res_status     = ST_HIT;
            res_idx        = scan_res.hit_idx;
            res_bytes      = scan_res.hit_size;
          end else begin
            // An evicted entry is dropped even if the fill does not happen.
            if (!scan_res.free && scan_res.evict) begin
              entry_valid_next[scan_res.evict_idx] = 1'b0;
            end
            if (claim_any && req_open_ok &&
                (req_bsize <= BSIZE_W'(max_entry_size))) begin
              entry_valid_next[claim_idx] = 1'b1;
              mem_we = 1'b1;
              // The entry stays filled after a failed read, but the request reports
              // that nothing was cached.
              if (req_read_ok) begin
                res_status = ST_FILLED;
                res_idx    = claim_idx;
                res_bytes  = req_bsize[SIZE_W-1:0];
              end
            end
          end
        end
      end
      OP_INVAL: begin
        if (req_cacheable && scan_res.hit) begin
          entry_valid_next[scan_res.hit_idx] = 1'b0;
          res_status = ST_INVALIDATED;
          res_idx    = scan_res.hit_idx;
        end
      end
      OP_INVAL_ALL: begin
        entry_valid_next = '0;
        res_status       = ST_ALL_CLEARED;
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (fire) begin
      entry_valid <= entry_valid_next;
    end
  end

  // Result register. It holds a finished result until the consumer takes it, while
  // the controller already goes back to accept the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status      <= res_status;
      slot        <= slot_t'(res_idx);
      entry_bytes <= res_bytes;
    end
  end

  // A match found by the scan must point at a valid entry.
  a_hit_valid : assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && req_cacheable && scan_res.hit) |-> entry_valid[scan_res.hit_idx])
    else $error("scan reported a match on an invalid entry");

  // A fill leaves the claimed entry valid.
  a_fill_valid : assert property (@(posedge clk) disable iff (rst)
    (fire && res_status == ST_FILLED) |=> entry_valid[$past(res_idx)])
    else $error("filled entry is not valid");

  // An invalidation leaves the entry invalid.
  a_inval_clear : assert property (@(posedge clk) disable iff (rst)
    (fire && res_status == ST_INVALIDATED) |=> !entry_valid[$past(res_idx)])
    else $error("invalidated entry is still valid");

  // A new result only appears out of the decision state.
  a_result_src : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DECIDE))
    else $error("result appeared outside the decision state");

endmodule
